### sv/page_frame_allocator_defines.svh
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is held
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page frame allocator: same-cycle check failed");

// next-cycle implication
`define PFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page frame allocator: next-cycle check failed");

`endif

### sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // directory geometry
  localparam int DIR_ENTRIES    = 1024;
  localparam int DIR_AW         = 10;
  localparam int ENTRY_W        = 14;
  localparam int ENTRY_FLAGS_W  = 4;
  localparam int ENTRY_FW       = 10;
  localparam int KERNEL_ENTRY_A = 0;
  localparam int KERNEL_ENTRY_B = 768;

  // entry flag bits
  localparam logic [ENTRY_FLAGS_W-1:0] FLAG_PRESENT = 4'b0001;
  localparam logic [ENTRY_FLAGS_W-1:0] FLAG_WRITE   = 4'b0010;
  localparam logic [ENTRY_FLAGS_W-1:0] FLAG_USER    = 4'b0100;
  localparam logic [ENTRY_FLAGS_W-1:0] FLAG_4MB     = 4'b1000;

  // request fields
  localparam int FUNC_W      = 2;
  localparam int AMOUNT_W    = 32;
  localparam int FRAME_SHIFT = 22;
  localparam int NEED_W      = AMOUNT_W - FRAME_SHIFT + 1;

  // result fields
  localparam int FRAME_OUT_W = 5;
  localparam int FREE_OUT_W  = 6;

  // frame map search window
  localparam int SCAN_W  = 32;
  localparam int SCAN_OW = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_LOW,
    ST_SEEK_NEXT,
    ST_SCAN_NEXT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic start_low;
    logic start_after_ptr;
    logic start_after_frame;
    logic frame_from_ptr;
    logic frame_from_scan;
    logic next_capture;
    logic next_none;
    logic out_check;
    logic out_fail;
    logic commit_alloc;
    logic commit_free;
  } ctl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              clr_last;
    logic              out_busy;
    logic              free_zero;
    logic              ptr_free;
    logic              ptr_last;
    logic              frame_last;
    logic              scan_done;
    logic              free_valid;
  } ctl_sts_t;

endpackage

`default_nettype wire

### sv/pfa_scan.sv
// ----------------------------------------------------------------------------
// pfa_scan
// finds the lowest free frame at or above a start position, one 32-frame
// window of the map per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_scan #(
  parameter int FRAMES = 32,
  parameter int PW     = $clog2(FRAMES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PW-1:0]     start_pos_i,
  input  wire logic [FRAMES-1:0] map_i,
  output logic                   done_o,
  output logic                   found_o,
  output logic [PW-1:0]          index_o
);

  localparam int NCHUNK = (FRAMES + pfa_pkg::SCAN_W - 1) / pfa_pkg::SCAN_W;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PADW   = NCHUNK * pfa_pkg::SCAN_W;
  localparam int XW     = CIW + pfa_pkg::SCAN_OW;

  logic                         busy_q;
  logic [CIW-1:0]               cur_q;
  logic [pfa_pkg::SCAN_OW-1:0]  lo_q;
  logic [XW-1:0]                start_x;
  logic [PADW-1:0]              padded;
  logic [PADW-1:0]              shifted;
  logic [pfa_pkg::SCAN_W-1:0]   cand;
  logic [pfa_pkg::SCAN_OW-1:0]  enc;
  logic                         hit;
  logic                         last;

  assign start_x = XW'(start_pos_i);

  // padding frames read as used so they are never picked
  always_comb begin
    padded              = '1;
    padded[FRAMES-1:0]  = map_i;
    shifted             = padded >> {cur_q, {pfa_pkg::SCAN_OW{1'b0}}};
    cand                = ~shifted[pfa_pkg::SCAN_W-1:0] &
                          ({pfa_pkg::SCAN_W{1'b1}} << lo_q);
  end

  always_comb begin
    enc = '0;
    for (int i = pfa_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        enc = pfa_pkg::SCAN_OW'(i);
      end
    end
  end

  assign hit     = |cand;
  assign last    = (cur_q == CIW'(NCHUNK - 1));
  assign done_o  = busy_q && (hit || last);
  assign found_o = busy_q && hit;
  assign index_o = PW'({cur_q, enc});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cur_q  <= '0;
      lo_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cur_q  <= start_x[XW-1:pfa_pkg::SCAN_OW];
      lo_q   <= start_x[pfa_pkg::SCAN_OW-1:0];
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cur_q  <= cur_q + CIW'(1);
      lo_q   <= '0;
    end
  end

endmodule

`default_nettype wire

### sv/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer of the allocator: directory clear after reset, request decode,
// frame searches and commit
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pfa_pkg::ctl_sts_t sts_i,
  output pfa_pkg::ctl_cmd_t      cmd_o
);

  pfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pfa_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      pfa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pfa_pkg::ST_EXEC;
        end
      end
      pfa_pkg::ST_EXEC: begin
        if (!sts_i.out_busy) begin
          case (pfa_pkg::func_e'(sts_i.func))
            pfa_pkg::FUNC_CHECK: begin
              cmd_o.out_check = 1'b1;
              state_d         = pfa_pkg::ST_IDLE;
            end
            pfa_pkg::FUNC_ALLOC: begin
              if (sts_i.free_zero) begin
                cmd_o.out_fail = 1'b1;
                state_d        = pfa_pkg::ST_IDLE;
              end else if (sts_i.ptr_free && sts_i.ptr_last) begin
                cmd_o.frame_from_ptr = 1'b1;
                cmd_o.next_none      = 1'b1;
                state_d              = pfa_pkg::ST_COMMIT;
              end else if (sts_i.ptr_free) begin
                cmd_o.frame_from_ptr  = 1'b1;
                cmd_o.start_after_ptr = 1'b1;
                state_d               = pfa_pkg::ST_SCAN_NEXT;
              end else begin
                cmd_o.start_low = 1'b1;
                state_d         = pfa_pkg::ST_SCAN_LOW;
              end
            end
            pfa_pkg::FUNC_FREE: begin
              if (sts_i.free_valid) begin
                cmd_o.commit_free = 1'b1;
              end else begin
                cmd_o.out_fail = 1'b1;
              end
              state_d = pfa_pkg::ST_IDLE;
            end
            default: begin
              cmd_o.out_fail = 1'b1;
              state_d        = pfa_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pfa_pkg::ST_SCAN_LOW: begin
        if (sts_i.scan_done) begin
          cmd_o.frame_from_scan = 1'b1;
          state_d               = pfa_pkg::ST_SEEK_NEXT;
        end
      end
      pfa_pkg::ST_SEEK_NEXT: begin
        if (sts_i.frame_last) begin
          cmd_o.next_none = 1'b1;
          state_d         = pfa_pkg::ST_COMMIT;
        end else begin
          cmd_o.start_after_frame = 1'b1;
          state_d                 = pfa_pkg::ST_SCAN_NEXT;
        end
      end
      pfa_pkg::ST_SCAN_NEXT: begin
        if (sts_i.scan_done) begin
          cmd_o.next_capture = 1'b1;
          state_d            = pfa_pkg::ST_COMMIT;
        end
      end
      pfa_pkg::ST_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit_alloc = 1'b1;
          state_d            = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/pfa_dpath.sv
// ----------------------------------------------------------------------------
// pfa_dpath
// frame map, free count, next-free pointer, page directory memory and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_frame_allocator_defines.svh"

module pfa_dpath #(
  parameter int FRAMES = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pfa_pkg::ctl_cmd_t                 cmd_i,
  output pfa_pkg::ctl_sts_t                      sts_o,
  input  wire logic [pfa_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [pfa_pkg::DIR_AW-1:0]        dir_index_i,
  input  wire logic [pfa_pkg::AMOUNT_W-1:0]      amount_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   ok_o,
  output logic [pfa_pkg::FRAME_OUT_W-1:0]        frame_index_o,
  output logic [pfa_pkg::FREE_OUT_W-1:0]         free_count_o
);

  localparam int PW  = $clog2(FRAMES);
  localparam int FCW = $clog2(FRAMES + 1);

  // request registers
  logic [pfa_pkg::FUNC_W-1:0]   func_q;
  logic [pfa_pkg::DIR_AW-1:0]   idx_q;
  logic [pfa_pkg::AMOUNT_W-1:0] amount_q;

  // allocator state, map bit set = frame in use
  logic [FRAMES-1:0] map_q;
  logic [FCW-1:0]    free_q, free_d;
  logic [PW-1:0]     ptr_q;
  logic [PW-1:0]     frame_q;
  logic [PW-1:0]     next_idx_q;
  logic              next_found_q;

  // directory
  logic [pfa_pkg::ENTRY_W-1:0] dir_mem [pfa_pkg::DIR_ENTRIES];
  logic [pfa_pkg::ENTRY_W-1:0] rd_q;
  logic [pfa_pkg::DIR_AW-1:0]  clr_cnt_q;
  logic [pfa_pkg::DIR_AW-1:0]  rd_addr, wr_addr;
  logic [pfa_pkg::ENTRY_W-1:0] wr_data;
  logic                        wr_en;

  // result register
  logic                          out_valid_q;
  logic                          ok_q;
  logic [pfa_pkg::FRAME_OUT_W-1:0] frame_out_q;
  logic [pfa_pkg::FREE_OUT_W-1:0]  count_out_q;

  logic                          out_busy;
  logic                          load_out;
  logic                          ok_d;
  logic [PW-1:0]                 frame_sel;
  logic [pfa_pkg::ENTRY_FW-1:0]  frame_wide;

  logic [pfa_pkg::ENTRY_FW-1:0]  rel_frame;
  logic [PW-1:0]                 rel_pos;
  logic                          rel_in_range;
  logic                          free_valid;
  logic [pfa_pkg::NEED_W-1:0]    need;
  logic                          fits;

  logic                          scan_start;
  logic [PW-1:0]                 scan_pos;
  logic                          scan_done, scan_found;
  logic [PW-1:0]                 scan_index;

  // entry being released and whether it may be
  assign rel_frame    = rd_q[pfa_pkg::ENTRY_W-1:pfa_pkg::ENTRY_FLAGS_W];
  assign rel_pos      = PW'(rel_frame);
  assign rel_in_range = ({1'b0, rel_frame} < (pfa_pkg::ENTRY_FW + 1)'(FRAMES));
  assign free_valid   = rel_in_range && map_q[rel_pos];

  // frames needed, rounded up
  assign need = pfa_pkg::NEED_W'(amount_q >> pfa_pkg::FRAME_SHIFT) +
                pfa_pkg::NEED_W'(amount_q[pfa_pkg::FRAME_SHIFT-1:0] != '0);
  assign fits = (need <= pfa_pkg::NEED_W'(free_q));

  // frame search
  assign scan_start = cmd_i.start_low | cmd_i.start_after_ptr | cmd_i.start_after_frame;

  always_comb begin
    scan_pos = '0;
    if (cmd_i.start_after_ptr) begin
      scan_pos = ptr_q + PW'(1);
    end else if (cmd_i.start_after_frame) begin
      scan_pos = frame_q + PW'(1);
    end
  end

  pfa_scan #(
    .FRAMES (FRAMES),
    .PW     (PW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .start_pos_i (scan_pos),
    .map_i       (map_q),
    .done_o      (scan_done),
    .found_o     (scan_found),
    .index_o     (scan_index)
  );

  // status towards the sequencer
  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.clr_last   = (clr_cnt_q == pfa_pkg::DIR_AW'(pfa_pkg::DIR_ENTRIES - 1));
    sts_o.out_busy   = out_busy;
    sts_o.free_zero  = (free_q == '0);
    sts_o.ptr_free   = !map_q[ptr_q];
    sts_o.ptr_last   = (ptr_q == PW'(FRAMES - 1));
    sts_o.frame_last = (frame_q == PW'(FRAMES - 1));
    sts_o.scan_done  = scan_done;
    sts_o.free_valid = free_valid;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      idx_q    <= dir_index_i;
      amount_q <= amount_i;
    end
  end

  // directory memory, one write and one registered read per cycle
  assign rd_addr = cmd_i.capture ? dir_index_i : idx_q;
  assign wr_en   = cmd_i.clr_en | cmd_i.commit_alloc | cmd_i.commit_free;
  assign wr_addr = cmd_i.clr_en ? clr_cnt_q : idx_q;

  always_comb begin
    wr_data = '0;
    if (cmd_i.clr_en) begin
      if (clr_cnt_q == pfa_pkg::DIR_AW'(pfa_pkg::KERNEL_ENTRY_A) ||
          clr_cnt_q == pfa_pkg::DIR_AW'(pfa_pkg::KERNEL_ENTRY_B)) begin
        wr_data = {{pfa_pkg::ENTRY_FW{1'b0}},
                   pfa_pkg::FLAG_PRESENT | pfa_pkg::FLAG_WRITE | pfa_pkg::FLAG_4MB};
      end
    end else if (cmd_i.commit_alloc) begin
      wr_data = {pfa_pkg::ENTRY_FW'(frame_q),
                 pfa_pkg::FLAG_PRESENT | pfa_pkg::FLAG_WRITE |
                 pfa_pkg::FLAG_USER | pfa_pkg::FLAG_4MB};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dir_mem[wr_addr] <= wr_data;
    end
    rd_q <= dir_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + pfa_pkg::DIR_AW'(1);
    end
  end

  // chosen frame and the pointer it leaves behind
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_from_ptr) begin
      frame_q <= ptr_q;
    end else if (cmd_i.frame_from_scan) begin
      frame_q <= scan_index;
    end
    if (cmd_i.next_capture) begin
      next_found_q <= scan_found;
      next_idx_q   <= scan_index;
    end else if (cmd_i.next_none) begin
      next_found_q <= 1'b0;
    end
  end

  always_comb begin
    free_d = free_q;
    if (cmd_i.commit_alloc) begin
      free_d = free_q - FCW'(1);
    end else if (cmd_i.commit_free) begin
      free_d = free_q + FCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= FRAMES'(1);
      free_q <= FCW'(FRAMES - 1);
      ptr_q  <= PW'(1);
    end else begin
      free_q <= free_d;
      if (cmd_i.commit_alloc) begin
        map_q[frame_q] <= 1'b1;
        ptr_q          <= next_found_q ? next_idx_q : frame_q;
      end else if (cmd_i.commit_free) begin
        map_q[rel_pos] <= 1'b0;
        if (ptr_q > rel_pos) begin
          ptr_q <= rel_pos;
        end
      end
    end
  end

  // result register
  assign load_out = cmd_i.out_check | cmd_i.out_fail | cmd_i.commit_alloc | cmd_i.commit_free;

  always_comb begin
    ok_d      = 1'b0;
    frame_sel = '0;
    if (cmd_i.out_check) begin
      ok_d = fits;
    end else if (cmd_i.commit_alloc) begin
      ok_d      = 1'b1;
      frame_sel = frame_q;
    end else if (cmd_i.commit_free) begin
      ok_d      = 1'b1;
      frame_sel = rel_pos;
    end
  end

  assign frame_wide = pfa_pkg::ENTRY_FW'(frame_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ok_q        <= ok_d;
      frame_out_q <= frame_wide[pfa_pkg::FRAME_OUT_W-1:0];
      count_out_q <= pfa_pkg::FREE_OUT_W'(free_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign frame_index_o = frame_out_q;
  assign free_count_o  = count_out_q;

  // free count tracks the clear bits of the map
  `PFA_ASSERT_IMP(a_count_matches_map, clk_i, rst_ni, 1'b1, $countones(~map_q) == free_q)
  // a frame handed out was free
  `PFA_ASSERT_IMP(a_alloc_takes_free, clk_i, rst_ni, cmd_i.commit_alloc, !map_q[frame_q])
  // a waiting result is never overwritten
  `PFA_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_busy, !load_out)
  // a committed result shows up as valid in the next cycle
  `PFA_ASSERT_NXT(a_load_shows, clk_i, rst_ni, load_out, out_valid_q)

endmodule

`default_nettype wire

### sv/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// allocator of 4 MB physical frames with a 1024-entry page directory.
// one request beat in, exactly one result beat out, in request order.
// requests: func 0 checks whether ceil(amount / 4 MB) frames are free,
// func 1 takes a free frame and maps it at dir_index, func 2 releases the
// frame that dir_index maps and clears the entry.
// after reset the directory is swept one entry a cycle, with in_stall_o
// high; it then holds only the two kernel mappings, frame 0 is in use and
// all other frames are free.
// one request is in work at a time. check, free and unused codes are
// answered straight from the execute state; allocate takes the frame at
// the next-free pointer, walks the 32-frame windows above it in search of
// the next free frame (no walk when the taken frame is the top one) and
// then commits. a stale next-free pointer adds a search for the lowest
// free frame first, and that frame is taken instead.
// the result register lets a request be accepted while the previous result
// waits; a stalled result holds, and the block then waits before writing
// the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator #(
  parameter int FRAMES = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [pfa_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [pfa_pkg::DIR_AW-1:0]         dir_index_i,
  input  wire logic [pfa_pkg::AMOUNT_W-1:0]       amount_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    ok_o,
  output logic [pfa_pkg::FRAME_OUT_W-1:0]         frame_index_o,
  output logic [pfa_pkg::FREE_OUT_W-1:0]          free_count_o
);

  // command and status between sequencer and datapath
  pfa_pkg::ctl_cmd_t cmd;
  pfa_pkg::ctl_sts_t sts;

  // sequencer: clear sweep, decode, searches, commit
  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: frame map, counters, directory memory, result register
  pfa_dpath #(
    .FRAMES (FRAMES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .dir_index_i   (dir_index_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .frame_index_o (frame_index_o),
    .free_count_o  (free_count_o)
  );

endmodule

`default_nettype wire
